// ===== rtl/core/ncws_pkg.sv =====
// Package for the nested comment / whitespace skipper.
// Holds character codes, counter widths and the result item type.
// No dependencies.
package ncws_pkg;

    // counter widths and limits
    localparam int MAX_NEST    = 255;
    localparam int DEPTH_W     = $clog2(MAX_NEST + 1);
    localparam int COLUMN_BITS = 16;
    localparam int COL_W       = 16;
    localparam int LINE_W      = 32;
    localparam int CHAR_W      = 8;

    localparam logic [COL_W-1:0] COL_CAP =
        (COLUMN_BITS >= COL_W) ? {COL_W{1'b1}} : COL_W'((64'd1 << COLUMN_BITS) - 64'd1);
    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

    // character codes
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'd11;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'd12;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'd42;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'd47;

    // one result item
    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              is_code;
        logic [LINE_W-1:0] line_number;
        logic [COL_W-1:0]  column;
        logic              run_last;
        logic              unterminated_comment;
    } result_t;

endpackage

// ===== rtl/core/nested_comment_whitespace_skipper.sv =====
// Top level of the nested comment / whitespace skipper.
// Classifies each byte as code or skipped text, tracks line and column.
// Depends on ncws_pkg.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+---------------------------
//  input   | in_valid in_ready char_in end_of_text     | one source byte per item
//  output  | out_valid out_ready char_out is_code      | zero to two results per
//          | line_number column run_last               | input item
//          | unterminated_comment                      |
//
// An input item is classified in the cycle it is accepted; its results sit in
// a three-entry result queue and leave one per cycle while out_ready is high,
// so one byte per cycle is sustained while each byte gives one result. A byte
// releasing a held '/' gives two results. in_ready is high while the queue
// holds at most one result. Reset clears the scanner state and empties the
// queue. A stalled output fills the queue and then drops in_ready.
module nested_comment_whitespace_skipper
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ncws_pkg::CHAR_W-1:0]    char_in,
    input  logic                           end_of_text,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ncws_pkg::CHAR_W-1:0]    char_out,
    output logic                           is_code,
    output logic [ncws_pkg::LINE_W-1:0]    line_number,
    output logic [ncws_pkg::COL_W-1:0]     column,
    output logic                           run_last,
    output logic                           unterminated_comment
);

    // scan modes
    localparam logic [1:0] MODE_CODE  = 2'd0;
    localparam logic [1:0] MODE_LINE  = 2'd1;
    localparam logic [1:0] MODE_BLOCK = 2'd2;

    // pending marks
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_SLASH = 2'd1;
    localparam logic [1:0] PEND_STAR  = 2'd2;
    localparam logic [1:0] PEND_BSL   = 2'd3;

    logic [1:0]                    mode_reg, mode_next;
    logic [1:0]                    pend_reg, pend_next;
    logic [ncws_pkg::DEPTH_W-1:0]  depth_reg, depth_next;
    logic [ncws_pkg::LINE_W-1:0]   line_reg, line_next;
    logic [ncws_pkg::COL_W-1:0]    col_reg, col_next;
    logic [1:0]                    count_reg, count_next;
    ncws_pkg::result_t             q_reg [0:2];
    ncws_pkg::result_t             q_next [0:2];

    // classification of the current item
    logic                          accept, pop;
    logic [1:0]                    n_res;
    logic [ncws_pkg::CHAR_W-1:0]   byte0, byte1;
    logic                          code0, code1;
    logic                          is_star, is_slash, is_skip, cb_code;
    logic [1:0]                    mode_new;
    logic [ncws_pkg::LINE_W-1:0]   line1, line2;
    logic [ncws_pkg::COL_W-1:0]    col1, col2;
    logic                          open_blk;
    logic [1:0]                    wp;
    ncws_pkg::result_t             res0, res1;

    // position after one emitted byte
    function automatic logic [ncws_pkg::LINE_W-1:0] adv_line(
        input logic [ncws_pkg::LINE_W-1:0] ln,
        input logic [ncws_pkg::CHAR_W-1:0] ch
    );
        if (ch == ncws_pkg::CH_NL && ln != ncws_pkg::LINE_MAX)
            return ln + 1'b1;
        return ln;
    endfunction

    function automatic logic [ncws_pkg::COL_W-1:0] adv_col(
        input logic [ncws_pkg::COL_W-1:0]  cl,
        input logic [ncws_pkg::CHAR_W-1:0] ch
    );
        if (ch == ncws_pkg::CH_NL)
            return '0;
        if (cl < ncws_pkg::COL_CAP)
            return cl + 1'b1;
        return cl;
    endfunction

    assign in_ready  = (count_reg <= 2'd1);
    assign accept    = in_valid && in_ready;
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;

    assign is_star  = (char_in == ncws_pkg::CH_STAR);
    assign is_slash = (char_in == ncws_pkg::CH_SLASH);
    assign is_skip  = (char_in == ncws_pkg::CH_TAB) || (char_in == ncws_pkg::CH_NL) ||
                      (char_in == ncws_pkg::CH_VT)  || (char_in == ncws_pkg::CH_FF) ||
                      (char_in == ncws_pkg::CH_CR)  || (char_in == ncws_pkg::CH_SPACE);
    assign cb_code  = !is_skip;

    // scanner next state and result bytes
    always_comb
    begin
        n_res      = 2'd1;
        byte0      = char_in;
        byte1      = char_in;
        code0      = 1'b0;
        code1      = 1'b0;
        mode_new   = mode_reg;
        pend_next  = PEND_NONE;
        depth_next = depth_reg;
        priority if (mode_reg == MODE_CODE)
        begin
            if (pend_reg == PEND_SLASH)
            begin
                byte0 = ncws_pkg::CH_SLASH;
                if (is_slash || is_star)
                begin
                    n_res = 2'd2;
                    code0 = 1'b0;
                    if (is_slash)
                        mode_new = MODE_LINE;
                    else
                    begin
                        mode_new   = MODE_BLOCK;
                        depth_next = ncws_pkg::DEPTH_W'(1);
                    end
                end
                else
                begin
                    // held slash released as code, then this byte as code unless it is whitespace
                    n_res = 2'd2;
                    code0 = 1'b1;
                    code1 = cb_code;
                end
            end
            else if (is_slash && !end_of_text)
            begin
                n_res     = 2'd0;
                pend_next = PEND_SLASH;
            end
            else
                code0 = cb_code;
        end
        else if (mode_reg == MODE_LINE)
        begin
            if (char_in == ncws_pkg::CH_NL)
                mode_new = MODE_CODE;
        end
        else
        begin
            // block comment
            mode_new = MODE_BLOCK;
            if (pend_reg == PEND_STAR && is_slash)
            begin
                if (depth_reg > 0)
                    depth_next = depth_reg - 1'b1;
                if (depth_reg <= ncws_pkg::DEPTH_W'(1))
                    mode_new = MODE_CODE;
            end
            else if (pend_reg == PEND_BSL && is_star)
            begin
                if (depth_reg < ncws_pkg::DEPTH_W'(ncws_pkg::MAX_NEST))
                    depth_next = depth_reg + 1'b1;
            end
            else if (is_star)
                pend_next = PEND_STAR;
            else if (is_slash)
                pend_next = PEND_BSL;
        end
    end

    // positions of the results
    assign line1    = adv_line(line_reg, byte0);
    assign col1     = adv_col(col_reg, byte0);
    assign line2    = adv_line(line1, byte1);
    assign col2     = adv_col(col1, byte1);
    assign open_blk = end_of_text && (mode_new == MODE_BLOCK);

    always_comb
    begin
        res0.char_out             = byte0;
        res0.is_code              = code0;
        res0.line_number          = line_reg;
        res0.column               = col_reg;
        res0.run_last             = (n_res == 2'd1);
        res0.unterminated_comment = open_blk;
        res1.char_out             = byte1;
        res1.is_code              = code1;
        res1.line_number          = line1;
        res1.column               = col1;
        res1.run_last             = 1'b1;
        res1.unterminated_comment = open_blk;
    end

    // state update; end of text returns the scanner state and position to reset values
    always_comb
    begin
        mode_next = mode_reg;
        line_next = line_reg;
        col_next  = col_reg;
        if (accept)
        begin
            mode_next = mode_new;
            unique case (n_res)
                2'd0:    begin line_next = line_reg; col_next = col_reg; end
                2'd1:    begin line_next = line1;    col_next = col1;    end
                default: begin line_next = line2;    col_next = col2;    end
            endcase
            if (end_of_text)
            begin
                mode_next = MODE_CODE;
                line_next = ncws_pkg::LINE_W'(1);
                col_next  = '0;
            end
        end
    end

    // result queue: shift on pop, write new results behind the survivors
    assign wp = count_reg - {1'b0, pop};

    always_comb
    begin
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        q_next[2] = q_reg[2];
        if (pop)
        begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
        end
        if (accept && n_res != 2'd0)
        begin
            q_next[wp] = res0;
            if (n_res == 2'd2)
                q_next[wp + 2'd1] = res1;
        end
        count_next = wp + (accept ? n_res : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_CODE;
            pend_reg  <= PEND_NONE;
            depth_reg <= '0;
            line_reg  <= ncws_pkg::LINE_W'(1);
            col_reg   <= '0;
            count_reg <= 2'd0;
        end
        else
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            count_reg <= count_next;
            if (accept)
            begin
                pend_reg  <= end_of_text ? PEND_NONE : pend_next;
                depth_reg <= end_of_text ? '0 : depth_next;
            end
        end
    end

    // queue payload, no reset
    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
        q_reg[2] <= q_next[2];
    end

    assign char_out             = q_reg[0].char_out;
    assign is_code              = q_reg[0].is_code;
    assign line_number          = q_reg[0].line_number;
    assign column               = q_reg[0].column;
    assign run_last             = q_reg[0].run_last;
    assign unterminated_comment = q_reg[0].unterminated_comment;

endmodule
